>>> design/smsort_pkg.sv
// Shared types and constants for the stable merge sorter.
// Command and status bundles between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package smsort_pkg;

    // Field widths of the stream payloads
    localparam int KEY_FIELD_W = 32;
    localparam int TAG_W       = 16;
    localparam int DATA_W      = 48;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_acc;   // input item accepted: store it or drop it
        logic pass_init;  // set closed: start the first merge pass
        logic pass_next;  // advance to the next pass, swap banks
        logic seg_init;   // set up the two runs of the next segment
        logic seg_next;   // advance to the next segment
        logic merge_wr;   // write the smaller head to the other bank
        logic emit_init;  // restart the emit pointer
        logic emit_sel;   // read port A follows the emit pointer
        logic emit_next;  // advance the emit pointer
        logic out_load;   // load the output register
        logic run_clear;  // clear count and overflow flag after the run
    } smsort_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pass_done;  // run width covers the whole set
        logic segs_done;  // all segments of this pass merged
        logic seg_done;   // both runs of this segment exhausted
        logic emit_last;  // emit pointer at the last stored item
        logic out_free;   // output register can take an item
    } smsort_stat_t;

endpackage

>>> design/stable_merge_sorter_core.sv
// Top level of the stable merge sorter: controller plus datapath.
// Depends on smsort_pkg, smsort_ctrl and smsort_dp.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------
//  s_axis   | in        | tdata {item_tag, sort_key}, tlast = final_item
//  m_axis   | out       | tdata {out_tag, out_key}, tlast = run_end,
//           |           | tuser = overflowed
//
//  Loading takes one item per cycle. The sort runs bottom-up merge passes,
//  ceil(log2 n) of them; each merge step reads the two run heads through the
//  memory's registered read ports, then writes the smaller one to the other
//  bank. Emit reads each item, then loads it once the output register is free.
//  Reset clears the count, the overflow flag and the output valid; the
//  memory needs no clearing. Input is taken only while loading; a stalled
//  result holds in the output register while the next set loads.

module stable_merge_sorter_core
    import smsort_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] sort_key, [47:32] item_tag
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] out_key, [47:32] out_tag
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // [0] overflowed
);

    smsort_cmd_t  cmd;
    smsort_stat_t stat;

    // Sequence load, merge passes and emit
    smsort_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Hold items, merge runs, drive results
    smsort_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> design/smsort_ctrl.sv
// Sequencing state machine of the stable merge sorter.
// Depends on smsort_pkg for the command and status bundles.
`timescale 1ns / 1ps

module smsort_ctrl
    import smsort_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tlast,
    output logic         s_axis_tready,
    input  smsort_stat_t stat,
    output smsort_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_SEG,
        S_RD,
        S_WR,
        S_ERD,
        S_EOUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.load_acc = 1'b1;
                    if (s_axis_tlast)
                    begin
                        cmd.pass_init = 1'b1;
                        state_next    = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                if (stat.pass_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_ERD;
                end
                else
                begin
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                if (stat.segs_done)
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = S_PASS;
                end
                else
                begin
                    cmd.seg_init = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                if (stat.seg_done)
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = S_SEG;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.merge_wr = 1'b1;
                state_next   = S_RD;
            end
            S_ERD:
            begin
                cmd.emit_sel = 1'b1;
                state_next   = S_EOUT;
            end
            S_EOUT:
            begin
                cmd.emit_sel = 1'b1;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.run_clear = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/smsort_dp.sv
// Datapath of the stable merge sorter: ping-pong item memory, run pointers,
// merge compare and the output register. Depends on smsort_pkg.
`timescale 1ns / 1ps

module smsort_dp
    import smsort_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DATA_W-1:0] s_axis_tdata,
    input  logic              m_axis_tready,
    input  smsort_cmd_t       cmd,
    output smsort_stat_t      stat,
    output logic              m_axis_tvalid,
    output logic [DATA_W-1:0] m_axis_tdata,
    output logic              m_axis_tlast,
    output logic              m_axis_tuser
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int WW     = CW + 1;
    localparam int SW     = CW + 2;
    localparam int KW     = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int WORD_W = KW + TAG_W;
    localparam int DEPTH  = 2 ** (AW + 1);

    // Two banks of item words: {tag, key}
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    logic [CW-1:0] cnt_reg;
    logic          drop_reg;
    logic          m_valid_reg;
    logic [WW-1:0] wid_reg;
    logic [SW-1:0] lo_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] le_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] re_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] e_reg;
    logic          src_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic          m_last_reg;
    logic          m_user_reg;

    logic              full;
    logic              we;
    logic [AW:0]       wa;
    logic [WORD_W-1:0] wd;
    logic [AW:0]       ra;
    logic [AW:0]       rb;
    logic [CW-1:0]     ra_idx;
    logic [WORD_W-1:0] in_word;
    logic [KW-1:0]     key_a;
    logic [KW-1:0]     key_b;
    logic              take_left;
    logic [SW-1:0]     n_ext;
    logic [SW-1:0]     lo_w;
    logic [SW-1:0]     lo_2w;
    logic [CW-1:0]     mid;
    logic [CW-1:0]     fin;
    logic [CW-1:0]     n_m1;

    assign full    = (cnt_reg == CW'(CAPACITY));
    assign in_word = {s_axis_tdata[KEY_FIELD_W +: TAG_W], s_axis_tdata[KW-1:0]};
    assign key_a   = rd_a_reg[KW-1:0];
    assign key_b   = rd_b_reg[KW-1:0];

    // Pick the left head on ties to keep load order
    assign take_left = (i_reg != le_reg) && ((j_reg == re_reg) || (key_a <= key_b));

    // Segment bounds, clipped to the set size
    assign n_ext = SW'(cnt_reg);
    assign lo_w  = lo_reg + SW'(wid_reg);
    assign lo_2w = lo_reg + (SW'(wid_reg) << 1);
    assign mid   = (lo_w  > n_ext) ? cnt_reg : lo_w[CW-1:0];
    assign fin   = (lo_2w > n_ext) ? cnt_reg : lo_2w[CW-1:0];
    assign n_m1  = cnt_reg - CW'(1);

    // Memory ports
    assign we     = (cmd.load_acc && !full) || cmd.merge_wr;
    assign wa     = cmd.merge_wr ? {~src_reg, k_reg[AW-1:0]} : {1'b0, cnt_reg[AW-1:0]};
    assign wd     = cmd.merge_wr ? (take_left ? rd_a_reg : rd_b_reg) : in_word;
    assign ra_idx = cmd.emit_sel ? e_reg : i_reg;
    assign ra     = {src_reg, ra_idx[AW-1:0]};
    assign rb     = {src_reg, j_reg[AW-1:0]};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    // Status to the controller
    assign stat.pass_done = (wid_reg >= WW'(cnt_reg));
    assign stat.segs_done = (lo_reg >= n_ext);
    assign stat.seg_done  = (i_reg == le_reg) && (j_reg == re_reg);
    assign stat.emit_last = (e_reg == n_m1);
    assign stat.out_free  = !m_valid_reg || m_axis_tready;

    // Count, overflow flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_clear)
            begin
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end
            else if (cmd.load_acc)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pass, segment and run pointers
    always_ff @(posedge clk)
    begin
        if (cmd.pass_init)
        begin
            wid_reg <= WW'(1);
            lo_reg  <= '0;
            k_reg   <= '0;
            src_reg <= 1'b0;
        end
        else if (cmd.pass_next)
        begin
            wid_reg <= wid_reg << 1;
            lo_reg  <= '0;
            k_reg   <= '0;
            src_reg <= ~src_reg;
        end
        else if (cmd.seg_next)
        begin
            lo_reg <= lo_2w;
        end
        if (cmd.seg_init)
        begin
            i_reg  <= lo_reg[CW-1:0];
            le_reg <= mid;
            j_reg  <= mid;
            re_reg <= fin;
        end
        else if (cmd.merge_wr)
        begin
            if (take_left)
            begin
                i_reg <= i_reg + CW'(1);
            end
            else
            begin
                j_reg <= j_reg + CW'(1);
            end
            k_reg <= k_reg + CW'(1);
        end
        if (cmd.emit_init)
        begin
            e_reg <= '0;
        end
        else if (cmd.emit_next)
        begin
            e_reg <= e_reg + CW'(1);
        end
        if (cmd.out_load)
        begin
            m_data_reg <= {rd_a_reg[WORD_W-1 -: TAG_W], KEY_FIELD_W'(key_a)};
            m_last_reg <= stat.emit_last;
            m_user_reg <= drop_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("item count beyond capacity");

    a_merge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_wr |-> (k_reg < cnt_reg) && !stat.seg_done)
        else $error("merge write outside the set or past both runs");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && stat.emit_last) |=> (cnt_reg == '0) && !drop_reg)
        else $error("set not cleared after the last item of the run");
`endif

endmodule
